// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

    // Result status codes.
    localparam logic [1:0] ST_UNIT = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // UTF-16 surrogate ranges and their high six bits.
    localparam logic [20:0] LEAD_FIRST  = 21'h00D800;
    localparam logic [20:0] LEAD_LAST   = 21'h00DBFF;
    localparam logic [20:0] TRAIL_FIRST = 21'h00DC00;
    localparam logic [20:0] TRAIL_LAST  = 21'h00DFFF;
    localparam logic [20:0] PLANE1_BASE = 21'h010000;
    localparam logic [5:0]  LEAD_HI     = 6'b110110;
    localparam logic [5:0]  TRAIL_HI    = 6'b110111;

    // Queue between the byte front end and the result back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded byte's worth of results: one or two entries.
    typedef struct packed {
        logic [20:0] unit0;
        logic [1:0]  status0;
        logic        two;
        logic [15:0] unit1;
    } u8u16_job_t;

endpackage

// File: rtl/u8u16_front.sv
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr,
    input  logic       cfg_data,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output u8u16_job_t job
);

    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [20:0] accum_reg, accum_next;
    logic        lead_pending_reg, lead_pending_next;
    logic [9:0]  lead_bits_reg, lead_bits_next;
    logic        skip_reg, skip_next;
    logic        sixteen_reg;

    logic [20:0] acc_shift;
    logic [1:0]  bl_dec;
    logic [20:0] cp;
    logic [20:0] joined;
    logic [20:0] offset;
    logic        do_finish;
    logic        do_fail;
    logic        fail_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= '0;
            accum_reg        <= '0;
            lead_pending_reg <= 1'b0;
            lead_bits_reg    <= '0;
            skip_reg         <= 1'b0;
            sixteen_reg      <= 1'b0;
        end
        else
        begin
            bytes_left_reg   <= bytes_left_next;
            accum_reg        <= accum_next;
            lead_pending_reg <= lead_pending_next;
            lead_bits_reg    <= lead_bits_next;
            skip_reg         <= skip_next;
            if (cfg_wr)
            begin
                sixteen_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        accum_next        = accum_reg;
        lead_pending_next = lead_pending_reg;
        lead_bits_next    = lead_bits_reg;
        skip_next         = skip_reg;
        push              = 1'b0;
        job               = '0;
        do_finish         = 1'b0;
        do_fail           = 1'b0;
        fail_zero         = 1'b0;
        cp                = '0;
        acc_shift         = {accum_reg[14:0], in_byte[5:0]};
        bl_dec            = bytes_left_reg - 2'd1;

        if (in_accept)
        begin
            if (skip_reg)
            begin
                if (in_byte == 8'd0)
                begin
                    skip_next = 1'b0;
                end
            end
            else if (bytes_left_reg != 2'd0)
            begin
                if (in_byte[7:6] != 2'b10)
                begin
                    do_fail   = 1'b1;
                    fail_zero = (in_byte == 8'd0);
                end
                else
                begin
                    accum_next      = acc_shift;
                    bytes_left_next = bl_dec;
                    if (bl_dec == 2'd0)
                    begin
                        do_finish  = 1'b1;
                        cp         = acc_shift;
                        accum_next = '0;
                    end
                end
            end
            else if (in_byte == 8'd0)
            begin
                lead_pending_next = 1'b0;
                lead_bits_next    = '0;
                push              = 1'b1;
                job.status0       = ST_END;
            end
            else if (!in_byte[7])
            begin
                do_finish = 1'b1;
                cp        = {13'd0, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                accum_next      = {16'd0, in_byte[4:0]};
                bytes_left_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                accum_next      = {17'd0, in_byte[3:0]};
                bytes_left_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                accum_next      = {18'd0, in_byte[2:0]};
                bytes_left_next = 2'd3;
            end
            else
            begin
                do_fail = 1'b1;
            end
        end

        // Code point complete: pair up surrogates, and in 16-bit mode split above the BMP.
        joined = {1'b0, lead_bits_reg, cp[9:0]} + PLANE1_BASE;
        offset = cp - PLANE1_BASE;
        if (do_finish)
        begin
            if (lead_pending_reg)
            begin
                if (cp < TRAIL_FIRST || cp > TRAIL_LAST)
                begin
                    do_fail = 1'b1;
                end
                else
                begin
                    lead_pending_next = 1'b0;
                    lead_bits_next    = '0;
                    push              = 1'b1;
                    job.status0       = ST_UNIT;
                    if (sixteen_reg)
                    begin
                        job.unit0 = {5'd0, LEAD_HI, lead_bits_reg};
                        job.two   = 1'b1;
                        job.unit1 = cp[15:0];
                    end
                    else
                    begin
                        job.unit0 = joined;
                    end
                end
            end
            else if (cp >= LEAD_FIRST && cp <= LEAD_LAST)
            begin
                lead_pending_next = 1'b1;
                lead_bits_next    = cp[9:0];
            end
            else
            begin
                push        = 1'b1;
                job.status0 = ST_UNIT;
                if (sixteen_reg && (cp[20:16] != 5'd0))
                begin
                    job.unit0 = {5'd0, LEAD_HI, offset[19:10]};
                    job.two   = 1'b1;
                    job.unit1 = {TRAIL_HI, offset[9:0]};
                end
                else
                begin
                    job.unit0 = cp;
                end
            end
        end

        if (do_fail)
        begin
            bytes_left_next   = '0;
            accum_next        = '0;
            lead_pending_next = 1'b0;
            lead_bits_next    = '0;
            skip_next         = !fail_zero;
            push              = 1'b1;
            job               = '0;
            job.status0       = ST_ERR;
        end
    end

endmodule

// File: rtl/u8u16_queue.sv
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u8u16_job_t push_job,
    input  logic       pop,
    output u8u16_job_t head_job,
    output logic       empty,
    output logic       full
);

    u8u16_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign empty    = (count_reg == QCNT_W'(0));
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_job = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/u8u16_back.sv
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  u8u16_job_t  head_job,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_unit,
    output logic [1:0]  status,
    output logic        last
);

    logic        out_valid_reg, out_valid_next;
    logic [20:0] code_unit_reg, code_unit_next;
    logic [1:0]  status_reg, status_next;
    logic        last_reg, last_next;
    logic        second_reg, second_next;
    logic [15:0] unit1_reg, unit1_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign code_unit = code_unit_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_unit_next = code_unit_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        second_next    = second_reg;
        unit1_next     = unit1_reg;
        pop            = 1'b0;
        if (out_free)
        begin
            if (second_reg)
            begin
                // Trailing surrogate of a pair already started.
                out_valid_next = 1'b1;
                code_unit_next = {5'd0, unit1_reg};
                status_next    = ST_UNIT;
                last_next      = 1'b1;
                second_next    = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                code_unit_next = head_job.unit0;
                status_next    = head_job.status0;
                last_next      = !head_job.two;
                second_next    = head_job.two;
                unit1_next     = head_job.unit1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_unit_reg <= code_unit_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
        unit1_reg     <= unit1_next;
    end

endmodule

// File: rtl/utf8_to_utf16_decoder_top.sv
// UTF-8 to UTF-16 / code point decoder.
// Input channel: one UTF-8 byte per request on in_byte, qualified by in_valid and
// held off by in_stall; a zero byte closes the string. Output channel: one result
// per request (code_unit, status, last), qualified by out_valid, held by out_stall.
// Configuration: a write request on cfg_valid/cfg_data sets the output mode
// (1 = surrogate pairs above 0xFFFF, 0 = 21-bit code points); cfg_ready is always
// high, and the mode should only be changed while the block is empty.
// Throughput is one byte per cycle while in_stall is low. A byte's first result
// goes through the queue and then the output register; a surrogate pair also holds
// the output for its second unit, which limits the rate on supplementary characters.
// The front end decodes a byte in the cycle it is taken, and a two-entry queue
// feeds the output register, so a stalled receiver first fills the output
// register and queue; only then does in_stall rise, which depends on registers only.
// Reset clears the decoder state, empties the queue and output register and
// selects 21-bit output.
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_unit,
    output logic [1:0]  status,
    output logic        last
);

    logic       in_accept;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;
    u8u16_job_t push_job;
    u8u16_job_t head_job;

    // A byte is taken whenever the queue has room.
    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign in_accept = in_valid && !full;

    u8u16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_byte   (in_byte),
        .push      (push),
        .job       (push_job)
    );

    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .status    (status),
        .last      (last)
    );

endmodule

// File: tb/utf8_to_utf16_decoder_top_test.sv
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top_test
    import u8u16_pkg::*;
();

    // One result as it leaves the decoder: a code unit or a status word.
    typedef struct packed {
        logic [20:0] unit_val;
        logic [1:0]  stat;
        logic        is_last;
    } unit_rec_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_ready;
    logic        in_stall;
    logic        out_valid;
    logic [20:0] code_unit;
    logic [1:0]  status;
    logic        last;

    // Results still owed by the decoder, oldest first, and the results of the
    // byte currently being decoded by the predictor.
    unit_rec_t expected_units[$];
    unit_rec_t step_units[$];

    // Predictor state, kept in step with the decoder's own registers.
    logic        sixteen_mode;
    logic [1:0]  pend_count;
    logic [20:0] partial_cp;
    logic        hi_waiting;
    logic [9:0]  hi_bits;
    logic        discarding;

    int mismatch_count = 0;
    int sent_bytes     = 0;

    // When set, neither side idles: requests go back to back.
    logic quiet = 1'b0;

    utf8_to_utf16_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_unit (code_unit),
        .status    (status),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void push_unit(input logic [20:0] v, input logic [1:0] st);
        unit_rec_t rec;
        rec.unit_val = v;
        rec.stat     = st;
        rec.is_last  = 1'b0;
        step_units.push_back(rec);
    endfunction

    // A malformed sequence wipes every partial result. Unless the offending
    // byte was the terminating zero itself, the rest of the string is dropped.
    function automatic void raise_error(input logic was_zero);
        pend_count = 2'd0;
        partial_cp = '0;
        hi_waiting = 1'b0;
        hi_bits    = '0;
        discarding = !was_zero;
        push_unit('0, ST_ERR);
    endfunction

    function automatic void emit_cp(input logic [20:0] cp);
        logic [20:0] offs;
        if (sixteen_mode && cp >= PLANE1_BASE)
        begin
            offs = cp - PLANE1_BASE;
            push_unit(LEAD_FIRST + {11'b0, offs[19:10]}, ST_UNIT);
            push_unit(TRAIL_FIRST + {11'b0, offs[9:0]}, ST_UNIT);
        end
        else
        begin
            push_unit(cp, ST_UNIT);
        end
    endfunction

    // A complete code point either pairs up with a waiting leading surrogate,
    // becomes the waiting surrogate itself, or goes straight out.
    function automatic void finish_cp(input logic [20:0] cp);
        logic [20:0] joined;
        if (hi_waiting)
        begin
            if (cp < TRAIL_FIRST || cp > TRAIL_LAST)
            begin
                raise_error(1'b0);
            end
            else
            begin
                hi_waiting = 1'b0;
                joined     = {1'b0, hi_bits, 10'b0} + (cp - TRAIL_FIRST) + PLANE1_BASE;
                hi_bits    = '0;
                emit_cp(joined);
            end
        end
        else if (cp >= LEAD_FIRST && cp <= LEAD_LAST)
        begin
            hi_waiting = 1'b1;
            hi_bits    = cp[9:0];
        end
        else
        begin
            emit_cp(cp);
        end
    endfunction

    // Works out what one accepted byte produces and queues it as expected.
    function automatic void decode_byte(input logic [7:0] b);
        unit_rec_t rec;
        step_units.delete();
        if (discarding)
        begin
            if (b == 8'h00)
                discarding = 1'b0;
            return;
        end
        if (pend_count != 2'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                raise_error(b == 8'h00);
            end
            else
            begin
                partial_cp = {partial_cp[14:0], b[5:0]};
                pend_count = pend_count - 2'd1;
                if (pend_count != 2'd0)
                    return;
                finish_cp(partial_cp);
                partial_cp = '0;
            end
        end
        else if (b == 8'h00)
        begin
            // The end of a string silently drops a lone leading surrogate.
            hi_waiting = 1'b0;
            hi_bits    = '0;
            push_unit('0, ST_END);
        end
        else if (b[7] == 1'b0)
        begin
            finish_cp({13'b0, b});
        end
        else if (b[7:5] == 3'b110)
        begin
            partial_cp = {16'b0, b[4:0]};
            pend_count = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            partial_cp = {17'b0, b[3:0]};
            pend_count = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            partial_cp = {18'b0, b[2:0]};
            pend_count = 2'd3;
        end
        else
        begin
            raise_error(1'b0);
        end
        for (int i = 0; i < step_units.size(); i++)
        begin
            rec         = step_units[i];
            rec.is_last = (i == step_units.size() - 1);
            expected_units.push_back(rec);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one byte request. The caller always stands at a rising edge, so
    // in_valid is either kept high for a back-to-back request or dropped for
    // the drawn number of idle cycles; it never toggles within one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        sent_bytes++;
        decode_byte(b);
    endtask

    // Holds the input back until every owed result has come out, then waits on
    // so that bytes still in flight without a result can settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic sixteen);
        cfg_valid <= 1'b1;
        cfg_data  <= sixteen;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        sixteen_mode  = sixteen;
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every lead form in 21-bit mode, up to the largest value a four-byte
    // sequence can carry, closed by the terminating zero.
    task automatic test_basic_decode();
        drain_results();
        set_mode(1'b0);
        send_bytes('{8'h41, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00});
    endtask

    // In 16-bit mode: a separately encoded surrogate pair is joined and split
    // again, and a leading surrogate at the end of the string is dropped.
    task automatic test_surrogates();
        drain_results();
        set_mode(1'b1);
        send_bytes('{8'hED, 8'hA0, 8'h80, 8'hED, 8'hB0, 8'h80,
                     8'hED, 8'hAF, 8'hBF, 8'h00});
    endtask

    // Bad lead byte with discarding, a continuation cut short by the zero,
    // a continuation replaced by ASCII, and a leading surrogate followed by
    // something other than its partner.
    task automatic test_malformed();
        send_bytes('{8'h80, 8'hFF, 8'h00,
                     8'hC2, 8'h00,
                     8'hC2, 8'h41, 8'h00,
                     8'hED, 8'hA0, 8'h80, 8'h41, 8'h00});
    endtask

    // Mostly well-formed text with random content, mixed with surrogate
    // pairs, broken sequences and the odd stray byte. Three phases run in 16-bit,
    // 21-bit and 16-bit mode, and each phase is drained before the switch.
    task automatic test_random_text();
        logic [7:0] b;
        int         kind;
        int         len;
        int         goal;
        for (int ph = 0; ph < 3; ph++)
        begin
            drain_results();
            set_mode(ph != 1);
            quiet = (ph == 1);
            goal  = sent_bytes + 140;
            while (sent_bytes < goal)
            begin
                if ($urandom_range(0, 29) == 0)
                    quiet = !quiet;
                kind = $urandom_range(0, 99);
                if (kind < 50)
                begin
                    len = $urandom_range(1, 4);
                    case (len)
                        1: b = 8'($urandom_range(8'h01, 8'h7F));
                        2: b = 8'($urandom_range(8'hC0, 8'hDF));
                        3: b = 8'($urandom_range(8'hE0, 8'hEF));
                        default: b = 8'($urandom_range(8'hF0, 8'hF7));
                    endcase
                    send_byte(b);
                    repeat (len - 1) send_byte(8'($urandom_range(8'h80, 8'hBF)));
                end
                else if (kind < 72)
                begin
                    // Leading surrogate, usually followed by a trailing one;
                    // a few strings end straight after it.
                    send_byte(8'hED);
                    send_byte(8'($urandom_range(8'hA0, 8'hAF)));
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
                    if (kind >= 65)
                    begin
                        send_byte(8'h00);
                    end
                    else if ($urandom_range(0, 4) != 0)
                    begin
                        send_byte(8'hED);
                        send_byte(8'($urandom_range(8'hB0, 8'hBF)));
                        send_byte(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    else
                    begin
                        send_byte(8'($urandom_range(8'h01, 8'h7F)));
                    end
                end
                else if (kind < 86)
                begin
                    if (kind < 80)
                    begin
                        // A lead byte whose continuation is not 10xxxxxx.
                        send_byte(8'($urandom_range(8'hC0, 8'hF7)));
                        if ($urandom_range(0, 3) == 0)
                        begin
                            b = 8'h00;
                        end
                        else
                        begin
                            do b = 8'($urandom); while (b[7:6] == 2'b10);
                        end
                        send_byte(b);
                    end
                    else
                    begin
                        b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                        : 8'($urandom_range(8'hF8, 8'hFF));
                        send_byte(b);
                    end
                    if ($urandom_range(0, 1) == 0)
                        send_byte(8'h00);
                end
                else if (kind < 94)
                begin
                    send_byte(8'h00);
                end
                else
                begin
                    send_byte(8'($urandom));
                end
            end
            // End the string so the next phase starts clean.
            send_byte(8'h00);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // The receiving side draws a stall length for every result, holds
    // out_stall for that long and then takes the next request that shows up.
    initial
    begin
        int        hold;
        unit_rec_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            if (expected_units.size() == 0)
            begin
                note_mismatch($sformatf("result %h/%0d/%0b with nothing expected",
                                        code_unit, status, last));
            end
            else
            begin
                want = expected_units.pop_front();
                if (code_unit !== want.unit_val)
                    note_mismatch($sformatf("code_unit %h, expected %h",
                                            code_unit, want.unit_val));
                if (status !== want.stat)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            status, want.stat));
                if (last !== want.is_last)
                    note_mismatch($sformatf("last %0b, expected %0b",
                                            last, want.is_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial
    begin
        sixteen_mode = 1'b0;
        pend_count   = 2'd0;
        partial_cp   = '0;
        hi_waiting   = 1'b0;
        hi_bits      = '0;
        discarding   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_decode();
        test_surrogates();
        test_malformed();
        test_random_text();

        // Everything is sent; wait for the last results and a little beyond
        // so that any stray extra result is still caught.
        in_valid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_units.size() == 0 && mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // A hung handshake ends the run here. The slowest correct run needs well
    // under half of this.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_decoder_top.sv
tb/utf8_to_utf16_decoder_top_test.sv
